[rtl/lkv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared item types, field widths and control structs of the cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 5;
    localparam int OCC_OUT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [KEY_W-1:0]   req_key;
        logic [VALUE_W-1:0] req_value;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [VALUE_W-1:0]   read_value;
        logic                 evicted;
        logic [KEY_W-1:0]     evicted_key;
        logic [VALUE_W-1:0]   evicted_value;
        logic [OCC_OUT_W-1:0] occupancy;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } t_cmd;

endpackage

[rtl/lru_key_value_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each input item is registered and goes through the lookup state (parallel
// key compare) and the commit state (rank and store update, loads the output
// register, waits while a stalled result holds it). A new item is taken only
// while idle or as the last commits; a waiting result does not hold off lookup.
// Reset clears valid marks, ranks and occupancy; capacity resets to 16.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lkv_pkg::t_req             i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lkv_pkg::t_rsp             o_out_item,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata
);
    import lkv_pkg::*;

    t_cmd cmd;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lkv_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/lkv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences each item through a lookup state and a commit state and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lkv_pkg::t_cmd o_cmd
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   commit;
    logic   accept;

    // The output register can take a new item when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_COMMIT) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) || commit);
    assign accept   = i_in_valid && !o_in_stall;

    assign o_cmd.accept = accept;
    assign o_cmd.lookup = (r_state == S_LOOKUP);
    assign o_cmd.commit = commit;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) n_state = accept ? S_LOOKUP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOKUP))
        else $error("accepted item did not enter lookup");

    a_lookup_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |=> (r_state == S_COMMIT))
        else $error("lookup not followed by commit");

    a_commit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("commit did not present a result item");

endmodule

[rtl/lkv_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache datapath
// Key, value, valid and recency storage with a parallel key compare in the
// lookup cycle and the rank and store update in the commit cycle.
// ----------------------------------------------------------------------------
module lkv_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkv_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata,
    input  lkv_pkg::t_req             i_in_item,
    output lkv_pkg::t_rsp             o_out_item
);
    import lkv_pkg::*;

    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

    // Storage
    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [VALUE_W-1:0] r_val [ENTRIES];
    logic [RW-1:0]      r_rank[ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]      r_occ;
    logic [CAP_W-1:0]   r_cap;
    t_req               r_req;
    t_rsp               r_rsp;

    // Lookup results
    logic               r_hit;
    logic [ENTRIES-1:0] r_match;
    logic [RW-1:0]      r_hit_rank;
    logic [VALUE_W-1:0] r_hit_val;
    logic               r_evict;
    logic [KEY_W-1:0]   r_ev_key;
    logic [VALUE_W-1:0] r_ev_val;
    logic               r_ins_ok;
    logic [ENTRIES-1:0] r_ins_vec;

    logic [ENTRIES-1:0] match, victim, free_vec;
    logic [RW-1:0]      hit_rank;
    logic [VALUE_W-1:0] hit_val;
    logic [KEY_W-1:0]   ev_key;
    logic [VALUE_W-1:0] ev_val;
    logic [CMPW-1:0]    cap_ext, cap_eff;
    logic               hit, full, is_put, evict, ins_ok;
    logic               c_put;
    logic [OW-1:0]      occ_next;

    assign is_put = (r_req.req_type == REQ_PUT);

    always_comb begin
        match    = '0;
        victim   = '0;
        hit_rank = '0;
        hit_val  = '0;
        ev_key   = '0;
        ev_val   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == r_req.req_key);
            victim[i] = r_valid[i] && (OW'(r_rank[i]) == (r_occ - OW'(1)));
            hit_rank  = hit_rank | (r_rank[i] & {RW{match[i]}});
            hit_val   = hit_val | (r_val[i] & {VALUE_W{match[i]}});
            ev_key    = ev_key | (r_key[i] & {KEY_W{victim[i]}});
            ev_val    = ev_val | (r_val[i] & {VALUE_W{victim[i]}});
        end
    end

    // Lowest-numbered invalid slot.
    assign free_vec = ~r_valid & (r_valid + ENTRIES'(1));
    assign hit      = |match;

    always_comb begin
        cap_ext = CMPW'(r_cap);
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = CMPW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            cap_eff = CMPW'(ENTRIES);
        end
    end

    assign full   = (CMPW'(r_occ) >= cap_eff) && (r_occ != '0);
    assign evict  = is_put && !hit && full && (|victim);
    assign ins_ok = is_put && !hit && (evict || (|free_vec));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_item;
        end
        if (i_cmd.lookup) begin
            r_hit      <= hit;
            r_match    <= match;
            r_hit_rank <= hit_rank;
            r_hit_val  <= hit_val;
            r_evict    <= evict;
            r_ev_key   <= ev_key;
            r_ev_val   <= ev_val;
            r_ins_ok   <= ins_ok;
            r_ins_vec  <= evict ? victim : free_vec;
        end
    end

    assign c_put    = (r_req.req_type == REQ_PUT);
    assign occ_next = (r_ins_ok && !r_evict) ? (r_occ + OW'(1)) : r_occ;

    // Key and value words carry no reset; only valid entries are read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_hit) begin
                    if (r_match[i] && c_put) r_val[i] <= r_req.req_value;
                end else if (r_ins_ok && r_ins_vec[i]) begin
                    r_key[i] <= r_req.req_key;
                    r_val[i] <= r_req.req_value;
                end
            end
            r_rsp.hit           <= r_hit;
            r_rsp.read_value    <= (r_hit && !c_put) ? r_hit_val : '0;
            r_rsp.evicted       <= r_evict;
            r_rsp.evicted_key   <= r_evict ? r_ev_key : '0;
            r_rsp.evicted_value <= r_evict ? r_ev_val : '0;
            r_rsp.occupancy     <= OCC_OUT_W'(occ_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_occ <= occ_next;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_hit) begin
                        // Entries more recent than the hit slot age by one.
                        if (r_match[i]) begin
                            r_rank[i] <= '0;
                        end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                            r_rank[i] <= r_rank[i] + RW'(1);
                        end
                    end else if (r_ins_ok) begin
                        // The evicted slot is the insert slot, so it is refilled here.
                        if (r_ins_vec[i]) begin
                            r_valid[i] <= 1'b1;
                            r_rank[i]  <= '0;
                        end else if (r_valid[i]) begin
                            r_rank[i] <= r_rank[i] + RW'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_out_item = r_rsp;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OW + 1)'(r_occ) <= (OW + 1)'(ENTRIES))
        else $error("occupancy above the number of entries");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy disagrees with the valid marks");

    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_ins_ok) |-> $onehot(r_ins_vec))
        else $error("insert slot is not unique");

    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_match))
        else $error("key present in more than one slot");

endmodule
